[rtl/ebpd_pkg.sv]
// Package with shared sizes, constants and control types for the packet deframer.
`timescale 1ns / 1ps
`default_nettype none

package ebpd_pkg;

    localparam int PACKET_BYTES = 64;
    localparam int CNT_W = $clog2(PACKET_BYTES + 1);
    localparam int ADDR_W = $clog2(PACKET_BYTES);
    localparam logic [7:0] ESCAPE_RESET = 8'hFF;

    typedef struct packed {
        logic take;
        logic fetch;
        logic advance;
    } ebpd_cmd_t;

    typedef struct packed {
        logic frame_end;
        logic empty_frame;
        logic last_beat;
    } ebpd_status_t;

endpackage

`default_nettype wire

[rtl/ebpd_if.sv]
// Stream interfaces for received link bytes and for emitted packet bytes.
`timescale 1ns / 1ps
`default_nettype none

interface ebpd_link_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ebpd_packet_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_empty;

    modport source (output valid, output out_byte, output out_last, output out_empty,
                    input ready);
    modport sink (input valid, input out_byte, input out_last, input out_empty,
                  output ready);
endinterface

`default_nettype wire

[rtl/escape_byte_packet_deframer.sv]
// Top level of the escape-byte packet deframer.
// A link byte is taken when valid and ready meet; the frame-end byte starts the read-out.
// Each packet byte is first read from the store into the read register, then shown as an output beat.
// An empty frame gives its single beat in the cycle after the frame-end byte is taken.
// No link byte is taken during read-out; the single store read port sets the output rate.
// Reset clears the fill count and escape flag and loads the escape byte with 0xFF.
`timescale 1ns / 1ps
`default_nettype none

module escape_byte_packet_deframer (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [7:0]   cfg_wdata,
    ebpd_link_if.sink         link,
    ebpd_packet_if.source     packet
);

    ebpd_pkg::ebpd_cmd_t    cmd;
    ebpd_pkg::ebpd_status_t status;

    ebpd_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (link.valid),
        .in_ready  (link.ready),
        .out_valid (packet.valid),
        .out_ready (packet.ready),
        .status    (status),
        .cmd       (cmd)
    );

    ebpd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rx_byte   (link.rx_byte),
        .cmd       (cmd),
        .status    (status),
        .out_byte  (packet.out_byte),
        .out_last  (packet.out_last),
        .out_empty (packet.out_empty)
    );

endmodule

`default_nettype wire

[rtl/ebpd_datapath.sv]
// Datapath of the deframer: packet store, fill count, escape flag and read-out registers.
`timescale 1ns / 1ps
`default_nettype none

module ebpd_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [7:0]           cfg_wdata,
    input  wire logic [7:0]           rx_byte,
    input  wire ebpd_pkg::ebpd_cmd_t  cmd,
    output ebpd_pkg::ebpd_status_t    status,
    output logic [7:0]                out_byte,
    output logic                      out_last,
    output logic                      out_empty
);

    logic [7:0]                  escape_reg;
    logic                        pending_reg;
    logic                        pending_next;
    logic [ebpd_pkg::CNT_W-1:0]  fill_reg;
    logic [ebpd_pkg::CNT_W-1:0]  fill_next;
    logic [ebpd_pkg::CNT_W-1:0]  fill_eff;
    logic [ebpd_pkg::CNT_W-1:0]  len_reg;
    logic [ebpd_pkg::CNT_W-1:0]  len_next;
    logic [ebpd_pkg::ADDR_W-1:0] rd_idx_reg;
    logic [ebpd_pkg::ADDR_W-1:0] rd_idx_next;
    logic [7:0]                  rdata_reg;
    logic                        store_en;
    logic                        end_mark;
    logic                        len_zero;

    logic [7:0] store_mem [ebpd_pkg::PACKET_BYTES];

    // A full store restarts at zero before the next byte is handled.
    assign fill_eff = (fill_reg == ebpd_pkg::CNT_W'(ebpd_pkg::PACKET_BYTES))
                      ? '0 : fill_reg;
    assign end_mark = pending_reg && (rx_byte == ~escape_reg);
    assign len_zero = (len_reg == '0);

    always_comb
    begin
        pending_next = pending_reg;
        fill_next    = fill_reg;
        len_next     = len_reg;
        rd_idx_next  = rd_idx_reg;
        store_en     = 1'b0;
        if (cmd.take)
        begin
            fill_next = fill_eff;
            if (pending_reg)
            begin
                pending_next = 1'b0;
                if (end_mark)
                begin
                    fill_next   = '0;
                    len_next    = fill_eff;
                    rd_idx_next = '0;
                end
                else
                begin
                    store_en  = 1'b1;
                    fill_next = fill_eff + ebpd_pkg::CNT_W'(1);
                end
            end
            else if (rx_byte == escape_reg)
            begin
                pending_next = 1'b1;
            end
            else
            begin
                store_en  = 1'b1;
                fill_next = fill_eff + ebpd_pkg::CNT_W'(1);
            end
        end
        if (cmd.advance)
        begin
            rd_idx_next = rd_idx_reg + ebpd_pkg::ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg  <= ebpd_pkg::ESCAPE_RESET;
            pending_reg <= 1'b0;
            fill_reg    <= '0;
            len_reg     <= '0;
            rd_idx_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                escape_reg <= cfg_wdata;
            end
            pending_reg <= pending_next;
            fill_reg    <= fill_next;
            len_reg     <= len_next;
            rd_idx_reg  <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            store_mem[fill_eff[ebpd_pkg::ADDR_W-1:0]] <= rx_byte;
        end
        if (cmd.fetch)
        begin
            rdata_reg <= store_mem[rd_idx_reg];
        end
    end

    assign status.frame_end   = end_mark;
    assign status.empty_frame = (fill_eff == '0);
    assign status.last_beat   = len_zero ||
                                (ebpd_pkg::CNT_W'(rd_idx_reg) + ebpd_pkg::CNT_W'(1) == len_reg);

    assign out_byte  = len_zero ? 8'h00 : rdata_reg;
    assign out_last  = status.last_beat;
    assign out_empty = len_zero;

endmodule

`default_nettype wire

[rtl/ebpd_controller.sv]
// Controller of the deframer: sequences byte intake and packet read-out.
`timescale 1ns / 1ps
`default_nettype none

module ebpd_controller (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire ebpd_pkg::ebpd_status_t status,
    output ebpd_pkg::ebpd_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SHOW
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready    = in_ready_reg;
    assign out_valid   = out_valid_reg;
    assign cmd.take    = in_valid && in_ready_reg;
    assign cmd.fetch   = (state_reg == ST_FETCH);
    assign cmd.advance = out_valid_reg && out_ready;

    always_comb
    begin
        state_next     = state_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = out_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.take && status.frame_end)
                begin
                    in_ready_next = 1'b0;
                    if (status.empty_frame)
                    begin
                        state_next     = ST_SHOW;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next     = ST_SHOW;
                out_valid_next = 1'b1;
            end
            ST_SHOW:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (status.last_beat)
                    begin
                        state_next    = ST_IDLE;
                        in_ready_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next     = ST_IDLE;
                in_ready_next  = 1'b1;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[test/ebpd_frame_checker.sv]
// Checker that predicts deframed packet beats from link beats and compares them with the output.
`timescale 1ns / 1ps

module ebpd_frame_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    ebpd_link_if            link,
    ebpd_packet_if          packet,
    output int              mismatch_count,
    output int              pending_beats
);

    typedef struct packed {
        logic [7:0] byte_val;
        logic       is_last;
        logic       is_empty;
    } packet_beat_t;

    packet_beat_t expected_beats[$];
    logic [7:0]   frame_store [ebpd_pkg::PACKET_BYTES];
    int unsigned  stored_count;
    logic         escape_armed;
    logic [7:0]   escape_byte;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic         keep;
        packet_beat_t beat;
        int unsigned  i;
        keep = 1'b0;
        if (stored_count >= ebpd_pkg::PACKET_BYTES)
        begin
            stored_count = 0;
        end
        if (escape_armed)
        begin
            if (b == ~escape_byte)
            begin
                if (stored_count == 0)
                begin
                    beat = '{byte_val: 8'h00, is_last: 1'b1, is_empty: 1'b1};
                    expected_beats.push_back(beat);
                end
                else
                begin
                    for (i = 0; i < stored_count; i++)
                    begin
                        beat = '{byte_val: frame_store[ebpd_pkg::ADDR_W'(i)],
                                 is_last: (i + 1 == stored_count),
                                 is_empty: 1'b0};
                        expected_beats.push_back(beat);
                    end
                end
                stored_count = 0;
            end
            else
            begin
                keep = 1'b1;
            end
            escape_armed = 1'b0;
        end
        else if (b == escape_byte)
        begin
            escape_armed = 1'b1;
        end
        else
        begin
            keep = 1'b1;
        end
        if (keep)
        begin
            frame_store[ebpd_pkg::ADDR_W'(stored_count)] = b;
            stored_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        packet_beat_t want;
        packet_beat_t got;
        if (!rst_n)
        begin
            expected_beats.delete();
            stored_count = 0;
            escape_armed = 1'b0;
            escape_byte = ebpd_pkg::ESCAPE_RESET;
        end
        else
        begin
            if (link.valid && link.ready)
            begin
                deframe_byte(link.rx_byte);
            end
            if (cfg_we)
            begin
                escape_byte = cfg_wdata;
            end
            if (packet.valid && packet.ready)
            begin
                got = '{byte_val: packet.out_byte, is_last: packet.out_last,
                        is_empty: packet.out_empty};
                if (expected_beats.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat byte=%02h last=%0b empty=%0b",
                                              got.byte_val, got.is_last, got.is_empty));
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (got.is_last !== want.is_last || got.is_empty !== want.is_empty ||
                        (!want.is_empty && got.byte_val !== want.byte_val))
                    begin
                        report_mismatch($sformatf(
                            {"expected byte=%02h last=%0b empty=%0b, ",
                             "got byte=%02h last=%0b empty=%0b"},
                            want.byte_val, want.is_last, want.is_empty,
                            got.byte_val, got.is_last, got.is_empty));
                    end
                end
            end
        end
        pending_beats = expected_beats.size();
    end

endmodule

[test/escape_byte_packet_deframer_tb.sv]
// Top of the deframer testbench: clock, reset, link stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module escape_byte_packet_deframer_tb;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    int         mismatch_count;
    int         pending_beats;
    int         items_sent;
    int         burst_left;
    logic [7:0] cur_escape;

    // With the reset escape byte: an empty frame, a frame with a stuffed escape and a bare
    // end mark, an escape followed by an ordinary byte, and a one-byte frame.
    logic [7:0] directed_bytes [18] = '{
        8'hFF, 8'hFE,
        8'h00, 8'hFF, 8'hFF, 8'h80, 8'hFE, 8'h7F, 8'h01, 8'hFF, 8'hFE,
        8'hFF, 8'h55, 8'hFF, 8'hFE,
        8'h12, 8'hFF, 8'hFE
    };

    ebpd_link_if   link();
    ebpd_packet_if packet();

    escape_byte_packet_deframer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .link      (link),
        .packet    (packet)
    );

    ebpd_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .link           (link),
        .packet         (packet),
        .mismatch_count (mismatch_count),
        .pending_beats  (pending_beats)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int mode;
        int span;
        packet.ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 150);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: packet.ready <= 1'b1;
                    1: packet.ready <= 1'($urandom_range(0, 1));
                    default: packet.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_link_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                link.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        link.valid <= 1'b1;
        link.rx_byte <= b;
        do
            @(posedge clk);
        while (!link.ready);
        items_sent++;
    endtask

    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 7))
            0: return cur_escape;
            1: return ~cur_escape;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame(input int len);
        logic [7:0] d;
        for (int k = 0; k < len; k++)
        begin
            d = pick_payload();
            if (d == cur_escape)
            begin
                send_link_byte(cur_escape);
            end
            send_link_byte(d);
        end
        send_link_byte(cur_escape);
        send_link_byte(~cur_escape);
    endtask

    task automatic drain_output();
        link.valid <= 1'b0;
        repeat (2) @(posedge clk);
        wait (pending_beats == 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_escape(input logic [7:0] v);
        drain_output();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_escape = v;
    endtask

    task automatic run_random_phase(input int budget);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                send_frame($urandom_range(60, 140));
            end
            else if (pick < 3)
            begin
                send_frame($urandom_range(11, 40));
            end
            else if (pick < 5)
            begin
                // Broken sequence: stray bytes and an escape that does not end the frame.
                repeat ($urandom_range(1, 4)) send_link_byte(pick_payload());
                send_link_byte(cur_escape);
                send_link_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                send_frame($urandom_range(0, 10));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 8'h00;
        link.valid = 1'b0;
        link.rx_byte = 8'h00;
        items_sent = 0;
        burst_left = 0;
        cur_escape = ebpd_pkg::ESCAPE_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
        begin
            send_link_byte(directed_bytes[i]);
        end
        run_random_phase(20);

        set_escape(8'h00);
        send_frame(0);
        send_frame(3);
        run_random_phase(20);

        set_escape(8'h80);
        run_random_phase(20);

        set_escape(8'($urandom_range(0, 255)));
        run_random_phase(20);

        set_escape(8'hFF);
        send_frame(64);
        send_frame(65);
        run_random_phase(20);

        drain_output();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
